// ===== sv/avs_pkg.sv =====
// Shared widths, codes, reset values and types of the presentation clock.
`default_nettype none
package avs_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SEL_W   = 4;
  localparam int unsigned DEC_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_FRAME    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESUME   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REANCHOR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESET    = 3'd5;

  localparam logic [DEC_W-1:0] DEC_PRESENT = 2'd0;
  localparam logic [DEC_W-1:0] DEC_DROP    = 2'd1;
  localparam logic [DEC_W-1:0] DEC_NONE    = 2'd2;

  localparam logic [SEL_W-1:0] STAT_LAST_LAG    = 4'd0;
  localparam logic [SEL_W-1:0] STAT_LAG_SUM     = 4'd1;
  localparam logic [SEL_W-1:0] STAT_SAMPLES     = 4'd2;
  localparam logic [SEL_W-1:0] STAT_LAG_MAX     = 4'd3;
  localparam logic [SEL_W-1:0] STAT_LAG_MIN     = 4'd4;
  localparam logic [SEL_W-1:0] STAT_LATE_DROPS  = 4'd5;
  localparam logic [SEL_W-1:0] STAT_EARLY_WAITS = 4'd6;
  localparam logic [SEL_W-1:0] STAT_WAIT_TOTAL  = 4'd7;
  localparam logic [SEL_W-1:0] STAT_PRESENTS    = 4'd8;
  localparam logic [SEL_W-1:0] STAT_PAUSES      = 4'd9;
  localparam logic [SEL_W-1:0] STAT_RESUMES     = 4'd10;
  localparam logic [SEL_W-1:0] STAT_RESETS      = 4'd11;

  localparam logic [CFG_IDX_W-1:0] CFG_LATE_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EARLY_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0] LATE_LIMIT_RESET  = 24'd80000;
  localparam logic [LIMIT_W-1:0] EARLY_LIMIT_RESET = 24'd250000;
  localparam logic [LIMIT_W-1:0] MIN_WAIT_US       = 24'd500;
  localparam logic [TIME_W-1:0]  LAG_MIN_RESET     = {1'b0, {(TIME_W-1){1'b1}}};

  typedef struct packed {
    logic [TIME_W-1:0]  host_anchor;
    logic [TIME_W-1:0]  media_anchor;
    logic               running;
    logic               frozen;
    logic [TIME_W-1:0]  pause_host_time;
    logic [TIME_W-1:0]  media_at_freeze;
    logic [TIME_W-1:0]  last_lag;
    logic [SUM_W-1:0]   lag_sum;
    logic [COUNT_W-1:0] lag_count;
    logic [TIME_W-1:0]  lag_max;
    logic [TIME_W-1:0]  lag_min;
    logic [COUNT_W-1:0] late_drop_count;
    logic [COUNT_W-1:0] early_wait_count;
    logic [SUM_W-1:0]   wait_total;
    logic [COUNT_W-1:0] present_count;
    logic [COUNT_W-1:0] pause_events;
    logic [COUNT_W-1:0] resume_events;
    logic [COUNT_W-1:0] reset_events;
  } avs_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] host_time_us;
    logic [TIME_W-1:0] pts_us;
    logic [SEL_W-1:0]  stat_select;
  } avs_event_t;

  typedef struct packed {
    logic [DEC_W-1:0]   decision;
    logic [LIMIT_W-1:0] wait_us;
    logic [TIME_W-1:0]  media_time_us;
    logic [TIME_W-1:0]  lag_us;
    logic               is_paused;
    logic [SUM_W-1:0]   stat_value;
  } avs_result_t;

  localparam avs_state_t STATE_RESET = '{
    host_anchor:      '0,
    media_anchor:     '0,
    running:          1'b0,
    frozen:           1'b0,
    pause_host_time:  '0,
    media_at_freeze:  '0,
    last_lag:         '0,
    lag_sum:          '0,
    lag_count:        '0,
    lag_max:          '0,
    lag_min:          LAG_MIN_RESET,
    late_drop_count:  '0,
    early_wait_count: '0,
    wait_total:       '0,
    present_count:    '0,
    pause_events:     '0,
    resume_events:    '0,
    reset_events:     '0
  };

endpackage
`default_nettype wire

// ===== sv/avs_req_if.sv =====
// Request channel carrying one clock event per transfer.
`default_nettype none
interface avs_req_if;
  import avs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [CMD_W-1:0]   command;
  logic        [TIME_W-1:0]  host_time_us;
  logic signed [TIME_W-1:0]  pts_us;
  logic        [SEL_W-1:0]   stat_select;

  modport source (output valid, command, host_time_us, pts_us, stat_select, input ready);
  modport sink   (input valid, command, host_time_us, pts_us, stat_select, output ready);
endinterface
`default_nettype wire

// ===== sv/avs_rsp_if.sv =====
// Response channel carrying one clock decision per transfer.
`default_nettype none
interface avs_rsp_if;
  import avs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [DEC_W-1:0]   decision;
  logic        [LIMIT_W-1:0] wait_us;
  logic signed [TIME_W-1:0]  media_time_us;
  logic signed [TIME_W-1:0]  lag_us;
  logic                      is_paused;
  logic signed [SUM_W-1:0]   stat_value;

  modport source (output valid, decision, wait_us, media_time_us, lag_us, is_paused,
                  stat_value, input ready);
  modport sink   (input valid, decision, wait_us, media_time_us, lag_us, is_paused,
                  stat_value, output ready);
endinterface
`default_nettype wire

// ===== sv/avs_core.sv =====
// Next-state and result logic for one clock event.
`default_nettype none
module avs_core (
  input  avs_pkg::avs_state_t              state_i,
  input  avs_pkg::avs_event_t              event_i,
  input  logic [avs_pkg::LIMIT_W-1:0]      late_limit_i,
  input  logic [avs_pkg::LIMIT_W-1:0]      early_limit_i,
  output avs_pkg::avs_state_t              state_o,
  output avs_pkg::avs_result_t             result_o
);
  import avs_pkg::*;

  logic [TIME_W-1:0]  host;
  logic [TIME_W-1:0]  pts;
  logic [TIME_W-1:0]  media_run;
  logic [TIME_W-1:0]  media_frame;
  logic [TIME_W-1:0]  lag_raw;
  logic [TIME_W-1:0]  early_abs;
  logic [LIMIT_W-1:0] early_clamp;
  logic               late;
  logic               grant;
  logic [TIME_W-1:0]  lag_final;
  avs_state_t         nx;
  logic               note_en;
  logic [DEC_W-1:0]   decision;
  logic [LIMIT_W-1:0] wait_us;
  logic [TIME_W-1:0]  lag_out;
  logic [TIME_W-1:0]  media_post;
  logic [SUM_W-1:0]   stat;

  assign host        = event_i.host_time_us;
  assign pts         = event_i.pts_us;
  assign media_run   = state_i.media_anchor + (host - state_i.host_anchor);
  assign media_frame = state_i.running ? media_run : pts;
  assign lag_raw     = media_frame - pts;
  assign late        = !lag_raw[TIME_W-1] && (lag_raw > TIME_W'(late_limit_i));
  assign early_abs   = '0 - lag_raw;
  assign early_clamp = (early_abs > TIME_W'(early_limit_i)) ? early_limit_i
                                                            : early_abs[LIMIT_W-1:0];
  assign grant       = lag_raw[TIME_W-1] && (early_clamp > MIN_WAIT_US);
  assign lag_final   = grant ? lag_raw + TIME_W'(early_clamp) : lag_raw;

  always_comb begin
    nx       = state_i;
    note_en  = 1'b0;
    decision = DEC_NONE;
    wait_us  = '0;
    lag_out  = '0;
    unique case (event_i.command) inside
      CMD_FRAME: begin
        if (state_i.frozen) begin
          decision = DEC_DROP;
        end else begin
          if (!state_i.running) begin
            nx.host_anchor     = host;
            nx.media_anchor    = pts;
            nx.running         = 1'b1;
            nx.frozen          = 1'b0;
            nx.pause_host_time = '0;
            nx.media_at_freeze = '0;
          end
          note_en = 1'b1;
          lag_out = lag_final;
          if (late) begin
            nx.late_drop_count = state_i.late_drop_count + 1'b1;
            decision           = DEC_DROP;
          end else begin
            if (grant) begin
              nx.early_wait_count = state_i.early_wait_count + 1'b1;
              nx.wait_total       = state_i.wait_total + SUM_W'(early_clamp);
              wait_us             = early_clamp;
            end
            nx.present_count = state_i.present_count + 1'b1;
            decision         = DEC_PRESENT;
          end
        end
      end
      CMD_PAUSE: begin
        if (state_i.running && !state_i.frozen) begin
          nx.media_at_freeze = media_run;
          nx.pause_host_time = host;
          nx.frozen          = 1'b1;
          nx.pause_events    = state_i.pause_events + 1'b1;
        end
      end
      CMD_RESUME: begin
        if (state_i.running && state_i.frozen) begin
          nx.host_anchor     = state_i.host_anchor + (host - state_i.pause_host_time);
          nx.frozen          = 1'b0;
          nx.pause_host_time = '0;
          nx.resume_events   = state_i.resume_events + 1'b1;
        end
      end
      CMD_REANCHOR, CMD_START: begin
        nx.host_anchor     = host;
        nx.media_anchor    = pts;
        nx.running         = 1'b1;
        nx.frozen          = 1'b0;
        nx.pause_host_time = '0;
        nx.media_at_freeze = '0;
        if (event_i.command == CMD_REANCHOR) begin
          nx.reset_events = state_i.reset_events + 1'b1;
        end
      end
      CMD_RESET: begin
        nx.host_anchor     = '0;
        nx.media_anchor    = '0;
        nx.pause_host_time = '0;
        nx.media_at_freeze = '0;
        nx.running         = 1'b0;
        nx.frozen          = 1'b0;
        nx.reset_events    = state_i.reset_events + 1'b1;
        nx.last_lag        = '0;
        nx.lag_sum         = '0;
        nx.lag_count       = '0;
        nx.lag_max         = '0;
        nx.lag_min         = LAG_MIN_RESET;
      end
      default: begin
      end
    endcase

    if (note_en) begin
      nx.last_lag  = lag_final;
      nx.lag_sum   = state_i.lag_sum + {{(SUM_W-TIME_W){lag_final[TIME_W-1]}}, lag_final};
      nx.lag_count = state_i.lag_count + 1'b1;
      if ($signed(lag_final) > $signed(state_i.lag_max)) begin
        nx.lag_max = lag_final;
      end
      if ($signed(lag_final) < $signed(state_i.lag_min)) begin
        nx.lag_min = lag_final;
      end
    end
  end

  assign media_post = !nx.running ? '0 :
                      nx.frozen   ? nx.media_at_freeze :
                                    nx.media_anchor + (host - nx.host_anchor);

  always_comb begin
    unique case (event_i.stat_select)
      STAT_LAST_LAG:    stat = {{(SUM_W-TIME_W){nx.last_lag[TIME_W-1]}}, nx.last_lag};
      STAT_LAG_SUM:     stat = nx.lag_sum;
      STAT_SAMPLES:     stat = SUM_W'(nx.lag_count);
      STAT_LAG_MAX:     stat = {{(SUM_W-TIME_W){nx.lag_max[TIME_W-1]}}, nx.lag_max};
      STAT_LAG_MIN:     stat = {{(SUM_W-TIME_W){nx.lag_min[TIME_W-1]}}, nx.lag_min};
      STAT_LATE_DROPS:  stat = SUM_W'(nx.late_drop_count);
      STAT_EARLY_WAITS: stat = SUM_W'(nx.early_wait_count);
      STAT_WAIT_TOTAL:  stat = nx.wait_total;
      STAT_PRESENTS:    stat = SUM_W'(nx.present_count);
      STAT_PAUSES:      stat = SUM_W'(nx.pause_events);
      STAT_RESUMES:     stat = SUM_W'(nx.resume_events);
      STAT_RESETS:      stat = SUM_W'(nx.reset_events);
      default:          stat = '0;
    endcase
  end

  assign state_o                = nx;
  assign result_o.decision      = decision;
  assign result_o.wait_us       = wait_us;
  assign result_o.media_time_us = media_post;
  assign result_o.lag_us        = lag_out;
  assign result_o.is_paused     = nx.frozen;
  assign result_o.stat_value    = stat;

endmodule
`default_nettype wire

// ===== sv/av_sync_presentation_clock.sv =====
// Top level of the media presentation clock with frame sync decisions.
//
//   Channel   Dir   Handshake      Content
//   req_i     in    valid/ready    command, host_time_us, pts_us, stat_select
//   rsp_o     out   valid/ready    decision, wait_us, media_time_us, lag_us,
//                                  is_paused, stat_value
//   cfg       in    cfg_we_i       late and early limits, one write per cycle
//
// A request passes an input register and then the result register before its
// response is offered; one request is taken every cycle while rsp_o is not stalled.
// The clock state updates in the same cycle the result register loads.
// A stalled response holds both registers while the input register still
// frees as soon as the result register can load.
// Reset clears the clock state, the statistics and the limits to their defaults.
`default_nettype none
module av_sync_presentation_clock (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  avs_req_if.sink                            req_i,
  avs_rsp_if.source                          rsp_o,
  input  logic                               cfg_we_i,
  input  logic [avs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [avs_pkg::LIMIT_W-1:0]        cfg_data_i
);
  import avs_pkg::*;

  logic [LIMIT_W-1:0] late_limit_q;
  logic [LIMIT_W-1:0] early_limit_q;
  logic               in_valid_q;
  avs_event_t         in_q;
  logic               out_valid_q;
  avs_result_t        out_q;
  avs_state_t         state_q;
  avs_state_t         state_d;
  avs_result_t        result_d;
  logic               advance;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      late_limit_q  <= LATE_LIMIT_RESET;
      early_limit_q <= EARLY_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LATE_LIMIT:  late_limit_q  <= cfg_data_i;
        CFG_EARLY_LIMIT: early_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q.command      <= req_i.command;
      in_q.host_time_us <= req_i.host_time_us;
      in_q.pts_us       <= req_i.pts_us;
      in_q.stat_select  <= req_i.stat_select;
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  avs_core u_avs_core (
    .state_i       (state_q),
    .event_i       (in_q),
    .late_limit_i  (late_limit_q),
    .early_limit_i (early_limit_q),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.decision      = out_q.decision;
  assign rsp_o.wait_us       = out_q.wait_us;
  assign rsp_o.media_time_us = out_q.media_time_us;
  assign rsp_o.lag_us        = out_q.lag_us;
  assign rsp_o.is_paused     = out_q.is_paused;
  assign rsp_o.stat_value    = out_q.stat_value;

endmodule
`default_nettype wire

// ===== sv/avs_checker.sv =====
// Port-level checks on the presentation clock responses, bound to the top level.
`default_nettype none
module avs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [avs_pkg::DEC_W-1:0]     decision_i,
  input logic [avs_pkg::LIMIT_W-1:0]   wait_us_i,
  input logic [avs_pkg::TIME_W-1:0]    lag_us_i,
  input logic                          is_paused_i
);
  import avs_pkg::*;

  a_wait_only_on_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (wait_us_i != '0) |-> (decision_i == DEC_PRESENT) &&
                                          (wait_us_i > MIN_WAIT_US))
    else $error("wait granted without a present decision or below the minimum");

  a_non_frame_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (decision_i == DEC_NONE) |-> (wait_us_i == '0) && (lag_us_i == '0))
    else $error("non-frame response carries a wait or a lag");

  a_paused_drop_no_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (decision_i == DEC_DROP) && is_paused_i |-> (lag_us_i == '0))
    else $error("frame dropped while paused reports a lag");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(decision_i) &&
                                    $stable(wait_us_i) && $stable(lag_us_i))
    else $error("stalled response changed");

endmodule

bind av_sync_presentation_clock avs_checker u_avs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .decision_i  (rsp_o.decision),
  .wait_us_i   (rsp_o.wait_us),
  .lag_us_i    (rsp_o.lag_us),
  .is_paused_i (rsp_o.is_paused)
);
`default_nettype wire

// ===== tb/sv/av_sync_presentation_clock_test.sv =====
// Self-checking testbench of the presentation clock: random events, limits and stalls.
module av_sync_presentation_clock_test;
  timeunit 1ns;
  timeprecision 1ps;
  import avs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
  localparam logic [SEL_W-1:0] STAT_NONE  = 4'd12;
  localparam logic [SEL_W-1:0] STAT_SPARE = 4'd15;

  class clock_scoreboard;
    bit [LIMIT_W-1:0] late_limit, early_limit;
    bit [TIME_W-1:0] host_anchor, media_anchor, pause_host, media_at_freeze;
    bit running, frozen;
    bit [TIME_W-1:0] last_lag, lag_max, lag_min;
    bit [SUM_W-1:0] lag_sum, wait_total;
    bit [COUNT_W-1:0] samples, late_drop_cnt, early_waits, presents, pauses, resumes, resets;
    avs_result_t pending_decisions[$];
    int unsigned errors;

    function new();
      late_limit = LATE_LIMIT_RESET;
      early_limit = EARLY_LIMIT_RESET;
      clear_lag_stats();
    endfunction

    function void clear_lag_stats();
      last_lag = '0;
      lag_sum = '0;
      samples = '0;
      lag_max = '0;
      lag_min = LAG_MIN_RESET;
    endfunction

    function bit [SUM_W-1:0] widen(bit [TIME_W-1:0] x);
      return {{(SUM_W-TIME_W){x[TIME_W-1]}}, x};
    endfunction

    function void anchor(bit [TIME_W-1:0] host, bit [TIME_W-1:0] base);
      host_anchor = host;
      media_anchor = base;
      running = 1'b1;
      frozen = 1'b0;
      pause_host = '0;
      media_at_freeze = '0;
    endfunction

    function bit [TIME_W-1:0] media_at(bit [TIME_W-1:0] host);
      if (!running) return '0;
      if (frozen) return media_at_freeze;
      return media_anchor + (host - host_anchor);
    endfunction

    function void record_lag(bit [TIME_W-1:0] lag);
      last_lag = lag;
      lag_sum += widen(lag);
      samples++;
      if ($signed(lag) > $signed(lag_max)) lag_max = lag;
      if ($signed(lag) < $signed(lag_min)) lag_min = lag;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] value);
      if (idx == CFG_LATE_LIMIT) late_limit = value;
      else early_limit = value;
    endfunction

    function void note_request(avs_event_t ev);
      avs_result_t r;
      bit [TIME_W-1:0] lag, early, media, host;
      r = '0;
      r.decision = DEC_NONE;
      lag = '0;
      host = ev.host_time_us;
      if (ev.command == CMD_FRAME) begin
        if (frozen) begin
          r.decision = DEC_DROP;
          media = media_at_freeze;
        end else begin
          if (!running) anchor(host, ev.pts_us);
          media = media_at(host);
          lag = media - ev.pts_us;
          if ($signed(lag) > $signed({{(TIME_W-LIMIT_W){1'b0}}, late_limit})) begin
            record_lag(lag);
            late_drop_cnt++;
            r.decision = DEC_DROP;
          end else begin
            if (lag[TIME_W-1]) begin
              early = -lag;
              if (early > TIME_W'(early_limit)) early = TIME_W'(early_limit);
              if (early > TIME_W'(MIN_WAIT_US)) begin
                early_waits++;
                wait_total += SUM_W'(early);
                r.wait_us = early[LIMIT_W-1:0];
                lag += early;
              end
            end
            record_lag(lag);
            presents++;
            r.decision = DEC_PRESENT;
          end
        end
      end else begin
        case (ev.command)
          CMD_PAUSE: begin
            if (running && !frozen) begin
              media_at_freeze = media_at(host);
              pause_host = host;
              frozen = 1'b1;
              pauses++;
            end
          end
          CMD_RESUME: begin
            if (running && frozen) begin
              host_anchor = host_anchor + (host - pause_host);
              frozen = 1'b0;
              pause_host = '0;
              resumes++;
            end
          end
          CMD_REANCHOR: begin
            anchor(host, ev.pts_us);
            resets++;
          end
          CMD_START: anchor(host, ev.pts_us);
          CMD_RESET: begin
            host_anchor = '0;
            media_anchor = '0;
            pause_host = '0;
            media_at_freeze = '0;
            running = 1'b0;
            frozen = 1'b0;
            resets++;
            clear_lag_stats();
          end
          default: ;
        endcase
        media = media_at(host);
      end
      r.media_time_us = media;
      r.lag_us = lag;
      r.is_paused = frozen;
      case (ev.stat_select)
        STAT_LAST_LAG:    r.stat_value = widen(last_lag);
        STAT_LAG_SUM:     r.stat_value = lag_sum;
        STAT_SAMPLES:     r.stat_value = SUM_W'(samples);
        STAT_LAG_MAX:     r.stat_value = widen(lag_max);
        STAT_LAG_MIN:     r.stat_value = widen(lag_min);
        STAT_LATE_DROPS:  r.stat_value = SUM_W'(late_drop_cnt);
        STAT_EARLY_WAITS: r.stat_value = SUM_W'(early_waits);
        STAT_WAIT_TOTAL:  r.stat_value = wait_total;
        STAT_PRESENTS:    r.stat_value = SUM_W'(presents);
        STAT_PAUSES:      r.stat_value = SUM_W'(pauses);
        STAT_RESUMES:     r.stat_value = SUM_W'(resumes);
        STAT_RESETS:      r.stat_value = SUM_W'(resets);
        default:          r.stat_value = '0;
      endcase
      pending_decisions.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t ns: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(avs_result_t got);
      avs_result_t exp;
      if (pending_decisions.size() == 0) begin
        report("response arrived with no request outstanding");
      end else begin
        exp = pending_decisions.pop_front();
        if (got.decision !== exp.decision)
          report($sformatf("decision %0d, expected %0d", got.decision, exp.decision));
        if (got.wait_us !== exp.wait_us)
          report($sformatf("wait_us %0d, expected %0d", got.wait_us, exp.wait_us));
        if (got.media_time_us !== exp.media_time_us)
          report($sformatf("media_time_us %h, expected %h", got.media_time_us,
                           exp.media_time_us));
        if (got.lag_us !== exp.lag_us)
          report($sformatf("lag_us %h, expected %h", got.lag_us, exp.lag_us));
        if (got.is_paused !== exp.is_paused)
          report($sformatf("is_paused %b, expected %b", got.is_paused, exp.is_paused));
        if (got.stat_value !== exp.stat_value)
          report($sformatf("stat_value %h, expected %h", got.stat_value, exp.stat_value));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [LIMIT_W-1:0] cfg_data_i;

  avs_req_if req ();
  avs_rsp_if rsp ();

  av_sync_presentation_clock dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  clock_scoreboard sb;
  bit steady;

  // Stimulus-side view of the media clock, used to pace host times and aim frame timestamps.
  bit [TIME_W-1:0] cursor_host, cursor_media;
  bit cursor_running, cursor_paused;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin : watch
    avs_result_t seen;
    avs_event_t taken;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        seen.decision = rsp.decision;
        seen.wait_us = rsp.wait_us;
        seen.media_time_us = rsp.media_time_us;
        seen.lag_us = rsp.lag_us;
        seen.is_paused = rsp.is_paused;
        seen.stat_value = rsp.stat_value;
        sb.check_result(seen);
      end
      if (req.valid && req.ready) begin
        taken.command = req.command;
        taken.host_time_us = req.host_time_us;
        taken.pts_us = req.pts_us;
        taken.stat_select = req.stat_select;
        sb.note_request(taken);
      end
    end
  end

  function automatic int unsigned pick_gap();
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  initial begin
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
    end
  end

  task automatic send_event(avs_event_t ev);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.command <= ev.command;
    req.host_time_us <= ev.host_time_us;
    req.pts_us <= ev.pts_us;
    req.stat_select <= ev.stat_select;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic send_fields(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] host,
                             logic [TIME_W-1:0] pts, logic [SEL_W-1:0] sel);
    avs_event_t ev;
    ev.command = cmd;
    ev.host_time_us = host;
    ev.pts_us = pts;
    ev.stat_select = sel;
    send_event(ev);
  endtask

  // The first edge lets the monitor record the last accepted request.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_decisions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(logic [LIMIT_W-1:0] late, logic [LIMIT_W-1:0] early);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_LATE_LIMIT;
    cfg_data_i <= late;
    @(posedge clk_i);
    cfg_index_i <= CFG_EARLY_LIMIT;
    cfg_data_i <= early;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(CFG_LATE_LIMIT, late);
    sb.set_limit(CFG_EARLY_LIMIT, early);
  endtask

  function automatic bit [TIME_W-1:0] wild_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Lags are aimed at the late and early thresholds and the minimum wait.
  function automatic longint pick_lag();
    longint late, early;
    late = sb.late_limit;
    early = sb.early_limit;
    case ($urandom_range(0, 9))
      0, 1: return longint'($urandom_range(0, 1200)) - 600;
      2: return late + longint'($urandom_range(0, 4)) - 2;
      3: return 2 - early - longint'($urandom_range(0, 4));
      4: return longint'($urandom_range(0, late));
      5: return -longint'($urandom_range(0, 2 * early));
      6: return late + 1 + longint'($urandom_range(0, 1 << 24));
      7: return longint'($signed(wild_time()));
      default: return longint'($urandom_range(0, 80000)) - 40000;
    endcase
  endfunction

  function automatic avs_event_t next_event();
    avs_event_t ev;
    bit [TIME_W-1:0] host, lag;
    int unsigned pick;
    if ($urandom_range(0, 99) == 0) host = wild_time();
    else host = cursor_host + TIME_W'($urandom_range(0, 40000));
    if (cursor_running && !cursor_paused) cursor_media += host - cursor_host;
    cursor_host = host;
    ev.host_time_us = host;
    ev.stat_select = SEL_W'($urandom_range(0, 15));
    ev.pts_us = ($urandom_range(0, 7) == 0) ? wild_time() : TIME_W'($urandom_range(0, 1 << 30));
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      ev.command = CMD_RESET;
      cursor_running = 1'b0;
      cursor_paused = 1'b0;
      cursor_media = '0;
    end else if (pick < 11) begin
      ev.command = (pick < 8) ? CMD_REANCHOR : CMD_START;
      cursor_running = 1'b1;
      cursor_paused = 1'b0;
      cursor_media = ev.pts_us;
    end else if (pick < 19) begin
      ev.command = CMD_PAUSE;
      if (cursor_running) cursor_paused = 1'b1;
    end else if (pick < 27) begin
      ev.command = CMD_RESUME;
      cursor_paused = 1'b0;
    end else if (pick < 31) begin
      ev.command = $urandom_range(0, 1) ? CMD_NOP : CMD_SPARE;
    end else begin
      ev.command = CMD_FRAME;
      if (!cursor_running) begin
        cursor_running = 1'b1;
        cursor_media = ev.pts_us;
      end else if (!cursor_paused) begin
        lag = TIME_W'(pick_lag());
        ev.pts_us = cursor_media - lag;
      end
    end
    return ev;
  endfunction

  initial begin
    int unsigned late, early;
    sb = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_LATE_LIMIT;
    cfg_data_i <= '0;
    req.valid <= 1'b0;
    req.command <= CMD_NOP;
    req.host_time_us <= '0;
    req.pts_us <= '0;
    req.stat_select <= STAT_LAST_LAG;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pause and resume before start, exact wait bounds, late limit edge,
    // frames while paused, time wrap, unused commands and stat selects.
    send_fields(CMD_PAUSE, 48'd0, 48'd0, STAT_LAG_MIN);
    send_fields(CMD_RESUME, 48'd0, 48'd0, STAT_RESUMES);
    send_fields(CMD_FRAME, 48'd1000, 48'd5000, STAT_SAMPLES);
    send_fields(CMD_FRAME, 48'd2000, 48'd257000, STAT_WAIT_TOTAL);
    send_fields(CMD_FRAME, 48'd3000, 48'd7500, STAT_EARLY_WAITS);
    send_fields(CMD_FRAME, 48'd4000, 48'd8501, STAT_LAST_LAG);
    send_fields(CMD_FRAME, 48'd5000, -48'sd71000, STAT_LAG_MAX);
    send_fields(CMD_FRAME, 48'd6000, -48'sd70001, STAT_LATE_DROPS);
    send_fields(CMD_PAUSE, 48'd7000, 48'd0, STAT_PAUSES);
    send_fields(CMD_PAUSE, 48'd8000, 48'd0, STAT_PAUSES);
    send_fields(CMD_FRAME, 48'd9000, 48'd0, STAT_PRESENTS);
    send_fields(CMD_RESUME, 48'd20000, 48'd0, STAT_RESUMES);
    send_fields(CMD_RESUME, 48'd21000, 48'd0, STAT_LAG_SUM);
    send_fields(CMD_REANCHOR, 48'd30000, 48'h7FFF_FFFF_FFFF, STAT_RESETS);
    send_fields(CMD_FRAME, 48'd30001, 48'h7FFF_FFFF_FFFF, STAT_LAG_MIN);
    send_fields(CMD_FRAME, 48'd30001, 48'd0, STAT_LAG_MIN);
    send_fields(CMD_START, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, STAT_NONE);
    send_fields(CMD_FRAME, 48'd5, 48'h7FFF_FFFF_FFFF, STAT_SAMPLES);
    send_fields(CMD_NOP, 48'd10, 48'd0, STAT_LAG_MIN);
    send_fields(CMD_SPARE, 48'd11, 48'hFFFF_FFFF_FFFF, STAT_SPARE);
    send_fields(CMD_RESET, 48'd12, 48'd0, STAT_RESETS);
    send_fields(CMD_NOP, 48'd13, 48'd0, STAT_LAG_MIN);
    send_fields(CMD_FRAME, 48'd14, 48'h0123_4567_89AB, STAT_LAG_MAX);
    send_fields(CMD_FRAME, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, STAT_LAG_SUM);
    send_fields(CMD_RESET, 48'd15, 48'd0, STAT_RESETS);

    for (int phase = 0; phase < 7; phase++) begin
      settle();
      case (phase)
        0: begin late = LATE_LIMIT_RESET; early = EARLY_LIMIT_RESET; end
        1: begin late = 0; early = 0; end
        2: begin late = 24'hFF_FFFF; early = 24'hFF_FFFF; end
        3: begin late = 1; early = 1; end
        4: begin late = 500; early = 501; end
        5: begin late = $urandom_range(0, 200000); early = $urandom_range(0, 600000); end
        default: begin late = $urandom & 24'hFF_FFFF; early = $urandom & 24'hFF_FFFF; end
      endcase
      write_limits(LIMIT_W'(late), LIMIT_W'(early));
      for (int k = 0; k < 130; k++) begin
        if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        send_event(next_event());
      end
    end
    steady = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_decisions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
